// ----- rtl/core/kli_pkg.sv -----
// Shared types and constants for the keyframe interpolator.
`default_nettype none
package kli_pkg;
   localparam int MaxKeys   = 64;
   localparam int IdxBits   = 6;
   localparam int FracBits  = 24;
   localparam int DivBits   = 33;          // divisor width (positive, up to 2^32-1)
   localparam int QuotBits  = FracBits + 1; // factor never exceeds 2^24-1, one guard

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_AFTER  = 2'd1,
      ST_BEFORE = 2'd2,
      ST_BADIDX = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD0,
      S_CHK0,
      S_SCAN,
      S_SCANW,
      S_DIV,
      S_RDV0,
      S_RDV1,
      S_RDV1W,
      S_MUL,
      S_DONE
   } state_type;

   // register indexes
   localparam logic [0:0] REG_KEY_COUNT = 1'd0;
endpackage
`default_nettype wire

// ----- rtl/core/kli_divider.sv -----
// Restoring divider: quotient = floor(num * 2^24 / den), one bit a cycle.
`default_nettype none
module kli_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go,
   input  wire logic [32:0] num,
   input  wire logic [32:0] den,
   output logic             done,
   output logic [23:0]      quot
);
   logic [33:0] rem_ff, rem_in;
   logic [56:0] sh_ff, sh_in;       // dividend bits shifted in from the top
   logic [23:0] q_ff, q_in;
   logic [32:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   // one quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[32:0], sh_ff[56]} - {1'b0, den_ff};
      if (go) begin
         rem_in = '0;
         sh_in  = {num, 24'd0};
         den_in = den;
         cnt_in = 6'd57;
         run_in = 1'b1;
      end else if (run_ff) begin
         sh_in = {sh_ff[55:0], 1'b0};
         if (!trial[33]) begin
            rem_in = trial;
            q_in   = {q_ff[22:0], 1'b1};
         end else begin
            rem_in = {rem_ff[32:0], sh_ff[56]};
            q_in   = {q_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

// ----- rtl/core/kli_blend.sv -----
// Per-axis blend: s + round_half_away(f * (e - s) / 2^24), registered multiply.
`default_nettype none
module kli_blend (
   input  wire logic               clock,
   input  wire logic signed [31:0] s,
   input  wire logic signed [31:0] e,
   input  wire logic [23:0]        f,
   output logic signed [31:0]      r
);
   logic signed [32:0] d;
   logic               neg;
   logic [32:0]        mag;
   logic [56:0]        prod_ff, prod_in;
   logic               neg_ff;
   logic signed [31:0] s_ff;
   logic [32:0]        rnd;
   logic [56:0]        sum;

   function automatic logic signed [32:0] s_ext(input logic signed [31:0] v);
      s_ext = {v[31], v};
   endfunction

   always_comb begin
      d       = 33'(s_ext(e)) - 33'(s_ext(s));
      neg     = d[32];
      mag     = neg ? 33'(-d) : 33'(d);
      prod_in = 57'(mag) * 57'(f);
   end

   // multiply stage
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg;
      s_ff    <= s;
   end

   // round half away from zero, apply sign
   always_comb begin
      sum = prod_ff + 57'(1 << 23);
      rnd = sum[56:24];
      r   = neg_ff ? 32'(s_ff - 32'(rnd)) : 32'(s_ff + 32'(rnd));
   end
endmodule
`default_nettype wire

// ----- rtl/core/keyframe_linear_interpolator.sv -----
// Top level of the keyframe interpolator: key memories, search sequencer, CSR.
//
//  channel  ports                        handshake
//  request  req_*                        start & !busy
//  result   rsp_*                        rsp_valid, one cycle, no stall
//  csr      csr_psel..csr_prdata         APB write at access with pready
//
// A write answers via S_DONE; busy holds off the next beat until its result beat is gone.
// A query reads key times one by one (S_SCANW, S_SCAN) until it lands in a segment, then runs
// the restoring divide, then reads both keys (S_RDV0, S_RDV1, S_RDV1W), multiplies (S_MUL)
// and answers. Clamped queries skip the divide. Reset is synchronous; key memories are not
// cleared. Results cannot stall.
`default_nettype none
module keyframe_linear_interpolator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_type,
   input  wire logic [5:0]         req_key_index,
   input  wire logic signed [31:0] req_key_time,
   input  wire logic signed [31:0] req_key_x,
   input  wire logic signed [31:0] req_key_y,
   input  wire logic signed [31:0] req_key_z,
   input  wire logic signed [31:0] req_query_time,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_z,
   output logic [5:0]              rsp_segment,
   output logic [1:0]              rsp_status,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [1:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   // memories
   logic signed [31:0] tmem [kli_pkg::MaxKeys];
   logic [95:0]        vmem [kli_pkg::MaxKeys];
   logic signed [31:0] trd_ff;
   logic [95:0]        vrd_ff;
   logic [5:0]         taddr, vaddr;
   logic               twe;

   logic [6:0]  kc_ff;
   kli_pkg::state_type st_ff, st_in;
   logic signed [31:0] q_ff, q_in;
   logic signed [31:0] t0_ff, t0_in;     // time of key i
   logic [5:0]  i_ff, i_in;
   logic [6:0]  n_ff, n_in;
   logic [5:0]  seg_ff, seg_in;
   logic [1:0]  stat_ff, stat_in;
   logic        interp_ff, interp_in;
   logic [95:0] v0_ff, v0_in;
   logic        dgo;
   logic        ddone;
   logic [23:0] fq;
   logic [32:0] dnum, dden;
   logic signed [31:0] bx, by, bz;
   logic        ov_ff, ov_in;
   logic signed [31:0] ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   logic [5:0]  os_ff, os_in;
   logic [1:0]  ost_ff, ost_in;
   logic        acc, cfgw;
   logic [32:0] dt33, dq33;

   assign acc  = start && !busy;
   assign cfgw = csr_psel && csr_penable && csr_pwrite;

   // CSR
   always_ff @(posedge clock) begin
      if (reset) begin
         kc_ff <= 7'd1;
      end else if (cfgw && csr_paddr[1:1] == kli_pkg::REG_KEY_COUNT) begin
         kc_ff <= csr_pwdata[6:0];
      end
   end
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:1] == kli_pkg::REG_KEY_COUNT) ? {25'd0, kc_ff} : 32'd0;

   // memories: one write port, registered read
   assign twe = acc && !req_type;
   always_ff @(posedge clock) begin
      if (twe) begin
         tmem[req_key_index] <= req_key_time;
         vmem[req_key_index] <= {req_key_z, req_key_y, req_key_x};
      end
      trd_ff <= tmem[taddr];
      vrd_ff <= vmem[vaddr];
   end

   assign dt33 = 33'({trd_ff[31], trd_ff}) - 33'({t0_ff[31], t0_ff});
   assign dq33 = 33'({q_ff[31], q_ff}) - 33'({t0_ff[31], t0_ff});

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         kli_pkg::S_IDLE: begin
            if (acc) st_in = req_type ? kli_pkg::S_RD0 : kli_pkg::S_DONE;
         end
         kli_pkg::S_RD0:   st_in = kli_pkg::S_CHK0;
         kli_pkg::S_CHK0: begin
            if (n_ff == 7'd1 || q_ff < trd_ff) st_in = kli_pkg::S_RDV0;
            else st_in = kli_pkg::S_SCANW;
         end
         kli_pkg::S_SCANW: st_in = kli_pkg::S_SCAN;
         kli_pkg::S_SCAN: begin
            if ({1'b0, i_ff} + 7'd1 >= n_ff) st_in = kli_pkg::S_RDV0;
            else if (q_ff < trd_ff) st_in = kli_pkg::S_DIV;
            else st_in = kli_pkg::S_SCANW;
         end
         kli_pkg::S_DIV:   if (ddone) st_in = kli_pkg::S_RDV0;
         kli_pkg::S_RDV0:  st_in = kli_pkg::S_RDV1;
         kli_pkg::S_RDV1:  st_in = kli_pkg::S_RDV1W;
         kli_pkg::S_RDV1W: st_in = kli_pkg::S_MUL;
         kli_pkg::S_MUL:   st_in = kli_pkg::S_DONE;
         kli_pkg::S_DONE:  st_in = kli_pkg::S_IDLE;
         default:          st_in = kli_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_in      = q_ff;
      t0_in     = t0_ff;
      i_in      = i_ff;
      n_in      = n_ff;
      seg_in    = seg_ff;
      stat_in   = stat_ff;
      interp_in = interp_ff;
      v0_in     = v0_ff;
      taddr     = i_ff;
      vaddr     = seg_ff;
      dgo       = 1'b0;
      dnum      = dq33;
      dden      = dt33;
      ov_in     = 1'b0;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      oz_in     = oz_ff;
      os_in     = os_ff;
      ost_in    = ost_ff;
      case (st_ff)
         kli_pkg::S_IDLE: begin
            taddr = 6'd0;
            if (acc) begin
               q_in      = req_query_time;
               i_in      = 6'd0;
               interp_in = 1'b0;
               seg_in    = req_key_index;
               stat_in   = kli_pkg::ST_OK;
               if (kc_ff == 7'd0) n_in = 7'd1;
               else if (kc_ff > 7'(kli_pkg::MaxKeys)) n_in = 7'(kli_pkg::MaxKeys);
               else n_in = kc_ff;
            end
         end
         kli_pkg::S_RD0: taddr = 6'd0;
         kli_pkg::S_CHK0: begin
            t0_in  = trd_ff;
            seg_in = 6'd0;
            taddr  = 6'd1;
            i_in   = 6'd0;
            if (n_ff == 7'd1) stat_in = kli_pkg::ST_OK;
            else if (q_ff < trd_ff) stat_in = kli_pkg::ST_BEFORE;
         end
         kli_pkg::S_SCANW: taddr = 6'(i_ff + 6'd1);
         kli_pkg::S_SCAN: begin
            // trd_ff holds time of key i+1
            taddr = 6'(i_ff + 6'd2);
            if ({1'b0, i_ff} + 7'd1 >= n_ff) begin
               seg_in  = 6'(n_ff - 7'd1);
               stat_in = kli_pkg::ST_AFTER;
            end else if (q_ff < trd_ff) begin
               seg_in    = i_ff;
               stat_in   = kli_pkg::ST_OK;
               interp_in = 1'b1;  // t0 <= q < t1 holds here, so dt > 0
               dgo       = 1'b1;
            end else begin
               t0_in = trd_ff;
               i_in  = 6'(i_ff + 6'd1);
            end
         end
         kli_pkg::S_RDV0: vaddr = seg_ff;
         kli_pkg::S_RDV1: begin
            v0_in = vrd_ff;
            vaddr = 6'(seg_ff + 6'd1);
         end
         kli_pkg::S_MUL: begin
            ov_in  = 1'b1;
            os_in  = seg_ff;
            ost_in = stat_ff;
            if (interp_ff) begin
               ox_in = bx; oy_in = by; oz_in = bz;
            end else begin
               ox_in = v0_ff[31:0]; oy_in = v0_ff[63:32]; oz_in = v0_ff[95:64];
            end
         end
         kli_pkg::S_DONE: begin
            if (!ov_ff) begin
               // write item result
               ov_in  = 1'b1;
               ox_in  = '0; oy_in = '0; oz_in = '0;
               os_in  = seg_ff;
               ost_in = kli_pkg::ST_OK;
            end
         end
         default: ;
      endcase
   end

   kli_divider u_div (
      .clock (clock), .reset (reset), .go (dgo),
      .num (dnum), .den (dden), .done (ddone), .quot (fq)
   );

   logic [23:0] f_ff;
   always_ff @(posedge clock) if (ddone) f_ff <= fq;

   // blend stages: v0_ff has key seg; key seg+1 is vrd_ff in S_RDV1W, v1_ff in S_MUL
   logic [95:0] v1_ff;
   always_ff @(posedge clock) if (st_ff == kli_pkg::S_RDV1W) v1_ff <= vrd_ff;
   kli_blend u_bx (.clock(clock), .s(v0_ff[31:0]),  .e(st_ff == kli_pkg::S_RDV1W ?
      vrd_ff[31:0] : v1_ff[31:0]), .f(f_ff), .r(bx));
   kli_blend u_by (.clock(clock), .s(v0_ff[63:32]), .e(st_ff == kli_pkg::S_RDV1W ?
      vrd_ff[63:32] : v1_ff[63:32]), .f(f_ff), .r(by));
   kli_blend u_bz (.clock(clock), .s(v0_ff[95:64]), .e(st_ff == kli_pkg::S_RDV1W ?
      vrd_ff[95:64] : v1_ff[95:64]), .f(f_ff), .r(bz));

   always_ff @(posedge clock) begin
      q_ff      <= q_in;
      t0_ff     <= t0_in;
      i_ff      <= i_in;
      n_ff      <= n_in;
      seg_ff    <= seg_in;
      stat_ff   <= stat_in;
      interp_ff <= interp_in;
      v0_ff     <= v0_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      oz_ff     <= oz_in;
      os_ff     <= os_in;
      ost_ff    <= ost_in;
      if (reset) begin
         st_ff <= kli_pkg::S_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
      end
   end

   assign busy        = (st_ff != kli_pkg::S_IDLE) || ov_ff;
   assign rsp_valid   = ov_ff;
   assign rsp_out_x   = ox_ff;
   assign rsp_out_y   = oy_ff;
   assign rsp_out_z   = oz_ff;
   assign rsp_segment = os_ff;
   assign rsp_status  = ost_ff;
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the keyframe linear interpolator.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_COUNT} row_kind_type;

   typedef struct {
      logic [31:0]         x, y, z;
      logic [5:0]          seg;
      kli_pkg::status_type st;
   } blend_result_type;

   typedef struct {
      row_kind_type     kind;
      logic [5:0]       idx;
      logic [31:0]      t, x, y, z, q;
      bit               typed;
      blend_result_type want;
   } stim_row_type;

   logic clock, reset, start, busy;
   logic req_type;
   logic [5:0] req_key_index;
   logic signed [31:0] req_key_time, req_key_x, req_key_y, req_key_z, req_query_time;
   logic rsp_valid;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [5:0] rsp_segment;
   logic [1:0] rsp_status;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   keyframe_linear_interpolator dut (.*);

   // shadow key table and count register
   longint     key_time_tab[kli_pkg::MaxKeys];
   longint     key_val_tab[kli_pkg::MaxKeys][3];
   int         active_keys = 1;
   blend_result_type pending_results[$];
   bit         failed = 0;
   int         burst_left = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("[keyframe_linear_interpolator] ERROR");
      $finish;
   end

   // start + round-half-away(f * (end - start) / 2^24)
   function automatic longint mix_axis(longint s, longint e, longint unsigned f);
      longint d;
      longint unsigned mag, hi, lo, r;
      d   = e - s;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      hi  = mag >> kli_pkg::FracBits;
      lo  = mag & ((64'd1 << kli_pkg::FracBits) - 1);
      r   = hi * f + ((lo * f + (64'd1 << (kli_pkg::FracBits - 1))) >> kli_pkg::FracBits);
      return (d < 0) ? s - longint'(r) : s + longint'(r);
   endfunction

   function automatic blend_result_type interpolate_at(logic [31:0] qt);
      blend_result_type r;
      longint q, dt, dq;
      longint unsigned f;
      int n, seg;
      bit interp, found;
      longint v;
      n = active_keys;
      if (n == 0) n = 1;
      if (n > kli_pkg::MaxKeys) n = kli_pkg::MaxKeys;
      q = longint'($signed(qt));
      seg = 0; r.st = kli_pkg::ST_OK; interp = 0; found = 0; f = 0;
      if (n == 1) begin
         seg = 0;
      end else if (q < key_time_tab[0]) begin
         r.st = kli_pkg::ST_BEFORE;
      end else begin
         seg = n - 1; r.st = kli_pkg::ST_AFTER;
         for (int i = 0; i + 1 < n; i++) begin
            if (!found && q < key_time_tab[i+1]) begin
               found = 1;
               dt = key_time_tab[i+1] - key_time_tab[i];
               dq = q - key_time_tab[i];
               seg = i; r.st = kli_pkg::ST_OK;
               if (dt > 0 && dq >= 0) begin
                  f = (longint'(dq) << kli_pkg::FracBits) / longint'(dt);
                  interp = 1;
               end
            end
         end
      end
      for (int a = 0; a < 3; a++) begin
         v = interp ? mix_axis(key_val_tab[seg][a], key_val_tab[seg+1][a], f)
                    : key_val_tab[seg][a];
         case (a)
            0: r.x = v[31:0];
            1: r.y = v[31:0];
            default: r.z = v[31:0];
         endcase
      end
      r.seg = seg[5:0];
      return r;
   endfunction

   // check each result beat against the oldest expectation
   always @(posedge clock) begin
      blend_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected");
            failed = 1;
         end else begin
            e = pending_results.pop_front();
            if (rsp_out_x !== e.x) begin
               $error("out_x expected %h got %h", e.x, rsp_out_x); failed = 1;
            end
            if (rsp_out_y !== e.y) begin
               $error("out_y expected %h got %h", e.y, rsp_out_y); failed = 1;
            end
            if (rsp_out_z !== e.z) begin
               $error("out_z expected %h got %h", e.z, rsp_out_z); failed = 1;
            end
            if (rsp_segment !== e.seg) begin
               $error("segment expected %0d got %0d", e.seg, rsp_segment); failed = 1;
            end
            if (rsp_status !== e.st) begin
               $error("status expected %0d got %0d", e.st, rsp_status); failed = 1;
            end
         end
      end
   end

   // drive one request beat, in bursts with random gaps; leave start high
   task automatic send_request(stim_row_type r);
      blend_result_type e;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
      burst_left--;
      start          <= 1'b1;
      req_type       <= (r.kind == ROW_QUERY);
      req_key_index  <= r.idx;
      req_key_time   <= r.t;
      req_key_x      <= r.x;
      req_key_y      <= r.y;
      req_key_z      <= r.z;
      req_query_time <= r.q;
      do @(posedge clock); while (busy);
      if (r.kind == ROW_WRITE) begin
         key_time_tab[r.idx]   = longint'($signed(r.t));
         key_val_tab[r.idx][0] = longint'($signed(r.x));
         key_val_tab[r.idx][1] = longint'($signed(r.y));
         key_val_tab[r.idx][2] = longint'($signed(r.z));
         e = '{x: 0, y: 0, z: 0, seg: r.idx, st: kli_pkg::ST_OK};
      end else begin
         e = interpolate_at(r.q);
      end
      pending_results = {pending_results, (r.typed ? r.want : e)};
   endtask

   // drain, then write and read back key_count
   task automatic set_key_count(int v);
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0 || busy);
      repeat (8) @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= 2'(4 * kli_pkg::REG_KEY_COUNT); csr_pwdata <= 32'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      active_keys = v & 127;
      csr_pwrite <= 1'b0; csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[6:0] !== 7'(v)) begin
         $error("key_count expected %0d got %0d", 7'(v), csr_prdata[6:0]); failed = 1;
      end
      csr_psel <= 1'b0; csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic stim_row_type mk(row_kind_type k, logic [5:0] idx,
                                       logic [31:0] t, x, y, z, q,
                                       bit typed, blend_result_type w);
      stim_row_type r;
      r = '{kind: k, idx: idx, t: t, x: x, y: y, z: z, q: q, typed: typed, want: w};
      return r;
   endfunction

   initial begin
      stim_row_type table_rows[$];
      blend_result_type k0, k3, none;
      stim_row_type r;
      longint tacc;
      int counts[6];
      int n, j;
      k0   = '{x: 32'h7fffffff, y: 32'h80000000, z: 0, seg: 0, st: kli_pkg::ST_OK};
      k3   = '{x: 32'h12345678, y: 32'hedcba988, z: 1, seg: 3, st: kli_pkg::ST_AFTER};
      none = '{x: 0, y: 0, z: 0, seg: 0, st: kli_pkg::ST_OK};

      start = 0; req_type = 0; req_key_index = 0; req_key_time = 0;
      req_key_x = 0; req_key_y = 0; req_key_z = 0; req_query_time = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      reset = 1;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed rows: extremes, clamps, single key, zero count
      table_rows = {table_rows, mk(ROW_WRITE, 0, 32'h80000001, 32'h7fffffff, 32'h80000000,
                                   0, 0, 1, none)};
      table_rows = {table_rows, mk(ROW_QUERY, 0, 0, 0, 0, 0, 32'h80000000, 1, k0)};
      table_rows = {table_rows, mk(ROW_QUERY, 0, 0, 0, 0, 0, 32'h7fffffff, 1, k0)};
      table_rows = {table_rows, mk(ROW_WRITE, 1, 0, 32'h80000000, 32'h7fffffff, 1, 0, 1,
                                   '{x: 0, y: 0, z: 0, seg: 1, st: kli_pkg::ST_OK})};
      table_rows = {table_rows, mk(ROW_WRITE, 2, 32'h10000, 0, 0, 32'hffffffff, 0, 1,
                                   '{x: 0, y: 0, z: 0, seg: 2, st: kli_pkg::ST_OK})};
      table_rows = {table_rows, mk(ROW_WRITE, 63, 32'h7fffffff, 32'hffffffff, 1,
                                   32'h7fffffff, 0, 1,
                                   '{x: 0, y: 0, z: 0, seg: 63, st: kli_pkg::ST_OK})};
      table_rows = {table_rows, mk(ROW_WRITE, 3, 32'h7fffffff, 32'h12345678, 32'hedcba988,
                                   1, 0, 1,
                                   '{x: 0, y: 0, z: 0, seg: 3, st: kli_pkg::ST_OK})};
      table_rows = {table_rows, mk(ROW_COUNT, 4, 0, 0, 0, 0, 0, 0, none)};
      table_rows = {table_rows, mk(ROW_QUERY, 0, 0, 0, 0, 0, 32'h80000000, 1,
                                   '{x: k0.x, y: k0.y, z: k0.z, seg: 0,
                                     st: kli_pkg::ST_BEFORE})};
      table_rows = {table_rows, mk(ROW_QUERY, 0, 0, 0, 0, 0, 32'h80000001, 1, k0)};
      table_rows = {table_rows, mk(ROW_QUERY, 0, 0, 0, 0, 0, 32'hc0000000, 0, none)};
      table_rows = {table_rows, mk(ROW_QUERY, 0, 0, 0, 0, 0, 32'h00008000, 0, none)};
      table_rows = {table_rows, mk(ROW_QUERY, 0, 0, 0, 0, 0, 32'h7ffffffe, 0, none)};
      table_rows = {table_rows, mk(ROW_QUERY, 0, 0, 0, 0, 0, 32'h7fffffff, 1, k3)};
      table_rows = {table_rows, mk(ROW_COUNT, 0, 0, 0, 0, 0, 0, 0, none)};
      table_rows = {table_rows, mk(ROW_QUERY, 0, 0, 0, 0, 0, 32'h7fffffff, 1, k0)};

      foreach (table_rows[i]) begin
         if (table_rows[i].kind == ROW_COUNT) set_key_count(table_rows[i].idx);
         else send_request(table_rows[i]);
      end

      // fill every slot with ascending times, some tight or repeated steps
      tacc = -(longint'(1) << 30);
      for (int i = 0; i < kli_pkg::MaxKeys; i++) begin
         case ($urandom_range(0, 7))
            0:       tacc += $urandom_range(0, 3);
            default: tacc += $urandom_range(1, 1 << 25);
         endcase
         send_request(mk(ROW_WRITE, i[5:0], tacc[31:0], $urandom, $urandom, $urandom, 0,
                         0, none));
      end

      // random phases over several key counts
      counts = '{64, 2, 127, 0, 1, 64};
      counts[4] = $urandom_range(3, 63);
      foreach (counts[p]) begin
         set_key_count(counts[p]);
         n = (counts[p] == 0) ? 1 :
             (counts[p] > kli_pkg::MaxKeys ? kli_pkg::MaxKeys : counts[p]);
         repeat (48) begin
            j = $urandom_range(0, n - 1);
            if ($urandom_range(0, 3) == 0) begin
               // rewrite a key: mostly nudge its time, sometimes scramble order
               r = mk(ROW_WRITE, 6'($urandom_range(0, kli_pkg::MaxKeys - 1)), 0, $urandom,
                      $urandom, $urandom, 0, 0, none);
               if ($urandom_range(0, 6) == 0) r.t = $urandom;
               else r.t = 32'(key_time_tab[r.idx] + $urandom_range(0, 6) - 3);
            end else begin
               r = mk(ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, none);
               case ($urandom_range(0, 9))
                  0:       r.q = $urandom;
                  1:       r.q = 32'(key_time_tab[j]);
                  2:       r.q = 32'(key_time_tab[j] - 1);
                  default: r.q = 32'(key_time_tab[j] + $urandom_range(0, 1 << 25));
               endcase
            end
            send_request(r);
         end
      end

      // wait out the tail
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (200) @(posedge clock);
      if (!failed) begin
         $display("[keyframe_linear_interpolator] OK");
      end else begin
         $display("[keyframe_linear_interpolator] ERROR");
      end
      $finish;
   end
endmodule

// ----- files.f -----
rtl/core/kli_pkg.sv
rtl/core/kli_divider.sv
rtl/core/kli_blend.sv
rtl/core/keyframe_linear_interpolator.sv
tb/tb.sv
